FILE: rtl/core/rgbhls_pkg.sv
package rgbhls_pkg;

    // Field widths
    localparam int unsigned ChanW = 8;
    localparam int unsigned HueW  = 15;
    localparam int unsigned SumW  = 9;
    localparam int unsigned SatW  = 16;

    // Divider shape: quotient bits per stage and stage counts
    localparam int unsigned SatQBits     = 16;
    localparam int unsigned HueQBits     = 12;
    localparam int unsigned BitsPerStage = 2;
    localparam int unsigned DivStages    = SatQBits / BitsPerStage;
    localparam int unsigned HueStages    = HueQBits / BitsPerStage;

    // Hue constants in 1/64 degree
    localparam logic [HueW-1:0] HueGreenBase = 15'd7680;
    localparam logic [HueW-1:0] HueBlueBase  = 15'd15360;
    localparam logic [HueW-1:0] HueFull      = 15'd23040;

    // Lightness sum thresholds
    localparam logic [SumW-1:0] HalfSum = 9'd255;
    localparam logic [SumW-1:0] FullSum = 9'd510;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Payload of one divider stage
    typedef struct packed {
        logic                grey;
        t_sector             sector;
        logic                hue_neg;
        logic [SumW-1:0]     sum;
        logic [ChanW-1:0]    sat_dvs;
        logic [ChanW-1:0]    sat_rem;
        logic [SatQBits-1:0] sat_sh;
        logic [ChanW-1:0]    hue_dvs;
        logic [ChanW-1:0]    hue_rem;
        logic [HueQBits-1:0] hue_sh;
    } t_div_stage;

    // One restoring-division step: returns {quotient bit, new remainder}
    function automatic logic [ChanW:0] div_bit(
        input logic [ChanW-1:0] rem,
        input logic             bit_in,
        input logic [ChanW-1:0] dvs
    );
        logic [ChanW:0] t;
        logic [ChanW:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            return {1'b1, diff[ChanW-1:0]};
        end else begin
            return {1'b0, t[ChanW-1:0]};
        end
    endfunction

endpackage

FILE: rtl/core/rgbhls_ifs.sv
interface rgbhls_pix_if;
    logic                            valid;
    logic                            ready;
    logic [rgbhls_pkg::ChanW-1:0]    red;
    logic [rgbhls_pkg::ChanW-1:0]    green;
    logic [rgbhls_pkg::ChanW-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhls_hls_if;
    logic                            valid;
    logic                            ready;
    logic [rgbhls_pkg::HueW-1:0]     hue;
    logic [rgbhls_pkg::SumW-1:0]     lightness_sum;
    logic [rgbhls_pkg::SatW-1:0]     saturation;

    modport source (output valid, output hue, output lightness_sum, output saturation,
                    input ready);
    modport sink   (input valid, input hue, input lightness_sum, input saturation,
                    output ready);
endinterface

FILE: rtl/core/rgb_to_hls_converter.sv
// RGB to HLS pixel converter, fully pipelined.
// Registers in order from input transfer to result valid: min/max, setup,
// 8 divider stages of 2 quotient bits each, output register.
// Throughput: one pixel per cycle; the whole pipe holds while the output stalls.
// Reset (synchronous, active low) clears all stage valid bits.
module rgb_to_hls_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rgbhls_pix_if.sink          i_pix,
    rgbhls_hls_if.source        o_hls
);

    localparam int unsigned NStg = rgbhls_pkg::DivStages;
    localparam int unsigned BPS  = rgbhls_pkg::BitsPerStage;
    localparam int unsigned W    = rgbhls_pkg::ChanW;
    localparam int unsigned SQ   = rgbhls_pkg::SatQBits;
    localparam int unsigned HQ   = rgbhls_pkg::HueQBits;

    logic advance;

    // Stage 1: min/max and hue numerator
    logic                    r_s1_vld;
    logic [W-1:0]            r_s1_mx;
    logic [W-1:0]            r_s1_mn;
    rgbhls_pkg::t_sector     r_s1_sector;
    logic [W-1:0]            r_s1_hnum;
    logic                    r_s1_hneg;

    logic [W-1:0]            n_s1_mx;
    logic [W-1:0]            n_s1_mn;
    rgbhls_pkg::t_sector     n_s1_sector;
    logic [W-1:0]            n_s1_hnum;
    logic                    n_s1_hneg;

    // Divider stages
    logic                    r_vld [0:NStg];
    rgbhls_pkg::t_div_stage  r_stg [0:NStg];
    rgbhls_pkg::t_div_stage  n_stg [0:NStg];

    // Output register
    logic                              r_out_vld;
    logic [rgbhls_pkg::HueW-1:0]       r_out_hue;
    logic [rgbhls_pkg::SumW-1:0]       r_out_sum;
    logic [rgbhls_pkg::SatW-1:0]       r_out_sat;
    logic [rgbhls_pkg::HueW-1:0]       n_out_hue;

    // Hold every stage while a finished result waits
    assign advance     = !r_out_vld || o_hls.ready;
    assign i_pix.ready = advance;

    // Find max/min channel and signed hue numerator
    always_comb begin
        logic [W:0] diff;
        n_s1_mx = i_pix.red;
        n_s1_mn = i_pix.red;
        if (i_pix.green > n_s1_mx) n_s1_mx = i_pix.green;
        if (i_pix.blue  > n_s1_mx) n_s1_mx = i_pix.blue;
        if (i_pix.green < n_s1_mn) n_s1_mn = i_pix.green;
        if (i_pix.blue  < n_s1_mn) n_s1_mn = i_pix.blue;
        if (i_pix.red == n_s1_mx) begin
            n_s1_sector = rgbhls_pkg::SEC_RED;
            diff        = {1'b0, i_pix.green} - {1'b0, i_pix.blue};
        end else if (i_pix.green == n_s1_mx) begin
            n_s1_sector = rgbhls_pkg::SEC_GREEN;
            diff        = {1'b0, i_pix.blue} - {1'b0, i_pix.red};
        end else begin
            n_s1_sector = rgbhls_pkg::SEC_BLUE;
            diff        = {1'b0, i_pix.red} - {1'b0, i_pix.green};
        end
        n_s1_hneg = diff[W];
        n_s1_hnum = diff[W] ? W'(-diff) : diff[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_mx     <= n_s1_mx;
            r_s1_mn     <= n_s1_mn;
            r_s1_sector <= n_s1_sector;
            r_s1_hnum   <= n_s1_hnum;
            r_s1_hneg   <= n_s1_hneg;
        end
    end

    // Set up divisors and dividends: d*65535 and 3840*num without multipliers
    always_comb begin
        logic [W-1:0]       d;
        logic [W:0]         sm;
        logic [W:0]         alt;
        logic [W+SQ-1:0]    sat_num;
        logic [W+HQ-1:0]    hue_num;
        d       = r_s1_mx - r_s1_mn;
        sm      = {1'b0, r_s1_mx} + {1'b0, r_s1_mn};
        alt     = rgbhls_pkg::FullSum - sm;
        sat_num = {d, {SQ{1'b0}}} - (W+SQ)'(d);
        hue_num = {r_s1_hnum, {HQ{1'b0}}} - (W+HQ)'({r_s1_hnum, 8'd0});
        n_stg[0].grey    = (d == '0);
        n_stg[0].sector  = r_s1_sector;
        n_stg[0].hue_neg = r_s1_hneg;
        n_stg[0].sum     = sm;
        n_stg[0].sat_dvs = (sm < rgbhls_pkg::HalfSum) ? sm[W-1:0] : alt[W-1:0];
        n_stg[0].sat_rem = sat_num[W+SQ-1:SQ];
        n_stg[0].sat_sh  = sat_num[SQ-1:0];
        n_stg[0].hue_dvs = d;
        n_stg[0].hue_rem = hue_num[W+HQ-1:HQ];
        n_stg[0].hue_sh  = hue_num[HQ-1:0];
    end

    // Divider stages: two quotient bits per stage, hue finishes early
    for (genvar k = 0; k < NStg; k++) begin : g_div
        always_comb begin
            logic [W:0] st;
            n_stg[k+1] = r_stg[k];
            for (int j = 0; j < BPS; j++) begin
                st = rgbhls_pkg::div_bit(n_stg[k+1].sat_rem, n_stg[k+1].sat_sh[SQ-1],
                                         n_stg[k+1].sat_dvs);
                n_stg[k+1].sat_rem = st[W-1:0];
                n_stg[k+1].sat_sh  = {n_stg[k+1].sat_sh[SQ-2:0], st[W]};
                if (k < rgbhls_pkg::HueStages) begin
                    st = rgbhls_pkg::div_bit(n_stg[k+1].hue_rem, n_stg[k+1].hue_sh[HQ-1],
                                             n_stg[k+1].hue_dvs);
                    n_stg[k+1].hue_rem = st[W-1:0];
                    n_stg[k+1].hue_sh  = {n_stg[k+1].hue_sh[HQ-2:0], st[W]};
                end
            end
        end
    end

    // Advance valid bits and payload through the divider
    for (genvar k = 0; k <= NStg; k++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (advance) begin
                r_vld[k] <= (k == 0) ? r_s1_vld : r_vld[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Place the sector fraction around its base angle
    always_comb begin
        logic [rgbhls_pkg::HueW-1:0] frac;
        frac = rgbhls_pkg::HueW'(r_stg[NStg].hue_sh);
        case (r_stg[NStg].sector)
            rgbhls_pkg::SEC_RED: begin
                n_out_hue = (r_stg[NStg].hue_neg && frac != '0) ?
                            rgbhls_pkg::HueFull - frac : frac;
            end
            rgbhls_pkg::SEC_GREEN: begin
                n_out_hue = r_stg[NStg].hue_neg ? rgbhls_pkg::HueGreenBase - frac :
                                                  rgbhls_pkg::HueGreenBase + frac;
            end
            rgbhls_pkg::SEC_BLUE: begin
                n_out_hue = r_stg[NStg].hue_neg ? rgbhls_pkg::HueBlueBase - frac :
                                                  rgbhls_pkg::HueBlueBase + frac;
            end
            default: begin
                n_out_hue = '0;
            end
        endcase
        if (r_stg[NStg].grey) n_out_hue = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_vld[NStg];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hue <= n_out_hue;
            r_out_sum <= r_stg[NStg].sum;
            r_out_sat <= r_stg[NStg].grey ? '0 : r_stg[NStg].sat_sh;
        end
    end

    assign o_hls.valid         = r_out_vld;
    assign o_hls.hue           = r_out_hue;
    assign o_hls.lightness_sum = r_out_sum;
    assign o_hls.saturation    = r_out_sat;

endmodule

FILE: verif/tb_rgb_to_hls_converter.sv
`timescale 1ns / 100ps

module tb_rgb_to_hls_converter;

    localparam int HueSector     = 3840;
    localparam int SatOne        = 65535;
    localparam int HoldOffCycles = 200;
    localparam int DrainCycles   = 30;
    localparam int RandChunks    = 12;
    localparam int ChunkItems    = 100;
    localparam int PressureItems = 80;
    localparam int NumDirected   = 24;
    localparam int MaxPrinted    = 50;

    typedef struct packed {
        logic [rgbhls_pkg::ChanW-1:0] red;
        logic [rgbhls_pkg::ChanW-1:0] green;
        logic [rgbhls_pkg::ChanW-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [rgbhls_pkg::HueW-1:0] hue;
        logic [rgbhls_pkg::SumW-1:0] lsum;
        logic [rgbhls_pkg::SatW-1:0] sat;
    } t_hls;

    // One directed pixel; the expected HLS is used only when typed is set
    typedef struct packed {
        t_pix px;
        logic typed;
        t_hls want;
    } t_dir_row;

    localparam t_dir_row DirTable [NumDirected] = '{
        // grey: black, white, mid grey
        '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{15'd0,     9'd0,   16'd0    }},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,     9'd510, 16'd0    }},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,     9'd256, 16'd0    }},
        // primaries
        '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{15'd0,     9'd255, 16'd65535}},
        '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{15'd7680,  9'd255, 16'd65535}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{15'd15360, 9'd255, 16'd65535}},
        // ties for the maximum: red wins, then green
        '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{15'd3840,  9'd255, 16'd65535}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{15'd19200, 9'd255, 16'd65535}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{15'd11520, 9'd255, 16'd65535}},
        // smallest spread, near black and near white
        '{'{8'd1,   8'd0,   8'd0  }, 1'b1, '{15'd0,     9'd1,   16'd65535}},
        '{'{8'd255, 8'd254, 8'd254}, 1'b1, '{15'd0,     9'd509, 16'd65535}},
        // sum just below and just above the half point
        '{'{8'd254, 8'd0,   8'd0  }, 1'b1, '{15'd0,     9'd254, 16'd65535}},
        '{'{8'd255, 8'd1,   8'd1  }, 1'b1, '{15'd0,     9'd256, 16'd65535}},
        // expected HLS from hls_of_pixel: red max with negative fraction, truncated toward zero, then mixed sectors
        '{'{8'd7,   8'd0,   8'd1  }, 1'b0, '0},
        '{'{8'd0,   8'd7,   8'd1  }, 1'b0, '0},
        '{'{8'd200, 8'd10,  8'd90 }, 1'b0, '0},
        '{'{8'd10,  8'd200, 8'd90 }, 1'b0, '0},
        '{'{8'd90,  8'd10,  8'd200}, 1'b0, '0},
        '{'{8'd127, 8'd128, 8'd0  }, 1'b0, '0},
        '{'{8'd128, 8'd127, 8'd255}, 1'b0, '0},
        '{'{8'd100, 8'd155, 8'd155}, 1'b0, '0},
        '{'{8'd0,   8'd255, 8'd128}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0},
        '{'{8'd5,   8'd250, 8'd5  }, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    rgbhls_pix_if pix_bus ();
    rgbhls_hls_if hls_bus ();

    rgb_to_hls_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_hls   (hls_bus)
    );

    t_hls pending_hls [$];
    int   mismatch_count = 0;
    int   pixels_sent    = 0;
    int   results_seen   = 0;
    int   pix_stalls     = 0;
    bit   src_steady     = 1'b0;
    bit   sink_steady    = 1'b0;
    bit   hold_out_req   = 1'b0;
    bit   hold_out_done  = 1'b0;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_hls.size());
        $display("Test completed with failures");
        $finish;
    end

    // Expected HLS of one pixel
    function automatic t_hls hls_of_pixel(input t_pix px);
        int                  r, g, b;
        int                  hi, lo, span, total, dvs, sat, h;
        rgbhls_pkg::t_sector sec;
        t_hls                res;
        r = px.red;
        g = px.green;
        b = px.blue;
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span  = hi - lo;
        total = hi + lo;
        sat   = 0;
        h     = 0;
        if (span != 0) begin
            dvs = (total < int'(rgbhls_pkg::HalfSum)) ? total :
                                                        int'(rgbhls_pkg::FullSum) - total;
            if (dvs != 0) sat = (span * SatOne) / dvs;
            if (sat > SatOne) sat = SatOne;
            // red wins a tie, then green
            if (r == hi) sec = rgbhls_pkg::SEC_RED;
            else if (g == hi) sec = rgbhls_pkg::SEC_GREEN;
            else sec = rgbhls_pkg::SEC_BLUE;
            case (sec)
                rgbhls_pkg::SEC_RED: begin
                    h = (HueSector * (g - b)) / span;
                    if (h < 0) h = h + int'(rgbhls_pkg::HueFull);
                end
                rgbhls_pkg::SEC_GREEN: begin
                    h = int'(rgbhls_pkg::HueGreenBase) + (HueSector * (b - r)) / span;
                end
                default: begin
                    h = int'(rgbhls_pkg::HueBlueBase) + (HueSector * (r - g)) / span;
                end
            endcase
        end
        res.hue  = rgbhls_pkg::HueW'(h);
        res.lsum = rgbhls_pkg::SumW'(total);
        res.sat  = rgbhls_pkg::SatW'(sat);
        return res;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random pixel, biased toward grey, extremes, ties and the ends of the sum range
    function automatic t_pix random_pixel();
        int   style, base, k, bright, sel;
        int   ch [3];
        t_pix px;
        style = $urandom_range(0, 99);
        base  = $urandom_range(0, 255);
        bright = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++) begin
            ch[i] = $urandom_range(0, 255);
            if (style >= 40 && style < 60) begin
                ch[i] = base + int'($urandom_range(0, 6)) - 3;
                if (ch[i] < 0) ch[i] = 0;
                if (ch[i] > 255) ch[i] = 255;
            end else if (style >= 60 && style < 75) begin
                k = $urandom_range(0, 4);
                if (k == 0) ch[i] = 0;
                else if (k == 1) ch[i] = 1;
                else if (k == 2) ch[i] = 254;
                else if (k == 3) ch[i] = 255;
            end else if (style >= 90) begin
                ch[i] = $urandom_range(0, 15) + (bright ? 240 : 0);
            end
        end
        // force a tie between two channels
        if (style >= 75 && style < 90) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) ch[1] = ch[0];
            else if (sel == 1) ch[2] = ch[0];
            else ch[2] = ch[1];
        end
        px.red   = 8'(ch[0]);
        px.green = 8'(ch[1]);
        px.blue  = 8'(ch[2]);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Compare one output transfer with the oldest pending expectation
    task automatic check_hls_result();
        t_hls want;
        results_seen++;
        if (pending_hls.size() == 0) begin
            report_mismatch("unexpected result, hue", hls_bus.hue, 0);
            return;
        end
        want = pending_hls.pop_front();
        if (hls_bus.hue !== want.hue)
            report_mismatch("hue", hls_bus.hue, want.hue);
        if (hls_bus.lightness_sum !== want.lsum)
            report_mismatch("lightness_sum", hls_bus.lightness_sum, want.lsum);
        if (hls_bus.saturation !== want.sat)
            report_mismatch("saturation", hls_bus.saturation, want.sat);
    endtask

    // Offer one pixel after a random idle stretch (none when src_steady); record its expectation on transfer
    task automatic send_pixel(input t_pix px, input logic typed, input t_hls want);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            pix_bus.valid <= 1'b0;
            {pix_bus.red, pix_bus.green, pix_bus.blue} <= 24'($urandom);
        end
        @(negedge i_clk);
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= px.red;
        pix_bus.green <= px.green;
        pix_bus.blue  <= px.blue;
        do @(posedge i_clk); while (!pix_bus.ready);
        pending_hls.push_back(typed ? want : hls_of_pixel(px));
        pixels_sent++;
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_pending();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (pending_hls.size() != 0) @(posedge i_clk);
    endtask

    // Output monitor and input stall counter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hls_bus.valid && hls_bus.ready) check_hls_result();
            if (pix_bus.valid && !pix_bus.ready) pix_stalls++;
        end
    end

    // Output ready: random runs and stalls, plus one long hold-off on request
    initial begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        hls_bus.ready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_out_req && !hold_out_done) begin
                hls_bus.ready <= 1'b0;
                repeat (HoldOffCycles - 1) @(negedge i_clk);
                hold_out_done = 1'b1;
            end else if (stall_left > 0 && !sink_steady) begin
                hls_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                hls_bus.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = $urandom_range(0, 30);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Reset and stimulus
    initial begin
        i_rst_n       = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels
        for (int i = 0; i < NumDirected; i++) begin
            send_pixel(DirTable[i].px, DirTable[i].typed, DirTable[i].want);
        end
        drain_pending();

        // Hold the output off while pixels keep coming, so the pipe backs up
        hold_out_req = 1'b1;
        src_steady   = 1'b1;
        repeat (PressureItems) send_pixel(random_pixel(), 1'b0, '0);
        while (!hold_out_done) @(posedge i_clk);
        src_steady = 1'b0;

        // Random pixels in chunks with varying idle behavior
        for (int k = 0; k < RandChunks; k++) begin
            src_steady  = (k % 4 == 1);
            sink_steady = (k % 2 == 1);
            if (k == RandChunks / 2) drain_pending();
            repeat (ChunkItems) send_pixel(random_pixel(), 1'b0, '0);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        drain_pending();
        repeat (DrainCycles) @(posedge i_clk);

        $display("Converted %0d pixels (%0d directed) and checked %0d results;",
                 pixels_sent, NumDirected, results_seen);
        $display("input stalled %0d cycles under output back-pressure, %0d mismatches.",
                 pix_stalls, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
